// ----- rtl/core/mbe_pkg.sv -----
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared widths, register indexes and status types for the escape-time block.
// ----------------------------------------------------------------------------
`default_nettype none

package mbe_pkg;

   localparam int WORD_W = 32;   // fixed-point word
   localparam int PIX_W  = 12;   // row / column index
   localparam int DIM_W  = 13;   // image width / height
   localparam int CNT_W  = 16;   // iteration count
   localparam int THR_W  = 8;    // escape threshold
   localparam int CSR_W  = 16;   // widest register
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ITERATIONS   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ESCAPE_THRESHOLD = 2'd3;

   localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH      = 13'd800;
   localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT     = 13'd800;
   localparam logic [CNT_W-1:0] RST_MAX_ITERATIONS   = 16'd256;
   localparam logic [THR_W-1:0] RST_ESCAPE_THRESHOLD = 8'd4;

   localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

`default_nettype wire

// ----- rtl/core/mbe_div.sv -----
// ----------------------------------------------------------------------------
// mbe_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mbe_div
   import mbe_pkg::*;
#(
   parameter int NUM_W = 36,
   parameter int DEN_W = 11
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] dividend,
   input  wire logic [DEN_W-1:0] divisor,
   output logic      [NUM_W-1:0] quotient,
   output div_stat_type          stat
);

   localparam int STEP_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [NUM_W-1:0]  num_ff, num_in;    // dividend shifts out, quotient shifts in
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff, den_in;

   logic [DEN_W:0] trial;
   logic [DEN_W:0] trial_sub;
   logic           fits;

   always_comb begin
      trial     = {rem_ff, num_ff[NUM_W-1]};
      fits      = (trial >= {1'b0, den_ff});
      trial_sub = trial - {1'b0, den_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;

      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         num_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         num_in  = {num_ff[NUM_W-2:0], fits};
         rem_in  = fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(NUM_W-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient  = num_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff) && !busy_ff)
      else $error("divider done without a run");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> rem_ff < den_ff)
      else $error("partial remainder not below divisor");

endmodule

`default_nettype wire

// ----- rtl/core/mbe_mult.sv -----
// ----------------------------------------------------------------------------
// mbe_mult
// Shared signed word multiplier with registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module mbe_mult
   import mbe_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic signed [WORD_W-1:0] op_a,
   input  wire logic signed [WORD_W-1:0] op_b,
   output logic signed [2*WORD_W-1:0]    prod
);

   logic signed [2*WORD_W-1:0] prod_ff, prod_in;

   always_comb begin
      prod_in = op_a * op_b;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

// ----- rtl/core/mandelbrot_escape_time.sv -----
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// Escape-time count for one pixel: maps row/column to c, iterates z = z^2 + c
// on one shared multiplier until |z|^2 reaches the threshold or the cap.
// ----------------------------------------------------------------------------
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   row_index, col_index
//   rsp      out        rsp_valid/rsp_stall   pixel_row, pixel_col, iter_count, in_set
//   csr      in         csr_write             csr_index, csr_wdata
//
// Coordinates and z are Q8.24 words at the default FRAC_BITS. Each coordinate costs
// one pass of the bit-serial divider; each iteration steps through MUL_RI, UPDATE,
// MUL_RR, MUL_II and CHECK around the single registered multiplier.
// Reset is synchronous and restores the register defaults.
// A stalled result sits in the output register; the next pixel is taken
// meanwhile and finishes only once that register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module mandelbrot_escape_time
   import mbe_pkg::*;
#(
   parameter int FRAC_BITS = 24
) (
   input  wire logic                 clock,
   input  wire logic                 reset,

   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [PIX_W-1:0]     req_row_index,
   input  wire logic [PIX_W-1:0]     req_col_index,

   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic      [PIX_W-1:0]     rsp_pixel_row,
   output logic      [PIX_W-1:0]     rsp_pixel_col,
   output logic      [CNT_W-1:0]     rsp_iter_count,
   output logic                      rsp_in_set,

   input  wire logic                 csr_write,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata
);

   localparam int NUM_W  = PIX_W + FRAC_BITS;
   localparam int DEN_W  = DIM_W - 2;
   localparam int PROD_W = 2*WORD_W;
   localparam int SQ_W   = PROD_W - FRAC_BITS;
   localparam int RI_W   = PROD_W - FRAC_BITS + 1;
   localparam int ACC_W  = PROD_W - FRAC_BITS + 2;
   localparam int EXT_W  = ((NUM_W > WORD_W) ? NUM_W : WORD_W) + 1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV_R_GO,
      ST_DIV_R_WAIT,
      ST_DIV_I_GO,
      ST_DIV_I_WAIT,
      ST_MUL_RI,
      ST_UPDATE,
      ST_MUL_RR,
      ST_MUL_II,
      ST_CHECK,
      ST_FINISH
   } state_type;

   function automatic logic signed [WORD_W-1:0] sat_acc(input logic signed [ACC_W-1:0] v);
      logic all_ones;
      logic all_zeros;
      all_ones  = &v[ACC_W-1:WORD_W-1];
      all_zeros = ~|v[ACC_W-1:WORD_W-1];
      if (all_ones || all_zeros) begin
         sat_acc = v[WORD_W-1:0];
      end else if (v[ACC_W-1]) begin
         sat_acc = WORD_MIN;
      end else begin
         sat_acc = WORD_MAX;
      end
   endfunction

   // Signed, saturated coordinate from magnitude quotient and sign.
   function automatic logic signed [WORD_W-1:0] coord(input logic neg,
                                                      input logic [NUM_W-1:0] q);
      logic [EXT_W-1:0] qx;
      logic             ovf;
      qx  = EXT_W'(q);
      ovf = |qx[EXT_W-1:WORD_W-1];
      if (neg) begin
         coord = ovf ? WORD_MIN : -$signed(qx[WORD_W-1:0]);
      end else begin
         coord = ovf ? WORD_MAX : $signed(qx[WORD_W-1:0]);
      end
   endfunction

   state_type                state_ff, state_in;
   logic [PIX_W-1:0]         row_ff, row_in;
   logic [PIX_W-1:0]         col_ff, col_in;
   logic signed [WORD_W-1:0] cr_ff, cr_in;
   logic signed [WORD_W-1:0] ci_ff, ci_in;
   logic signed [WORD_W-1:0] zr_ff, zr_in;
   logic signed [WORD_W-1:0] zi_ff, zi_in;
   logic signed [SQ_W-1:0]   rr_ff, rr_in;
   logic signed [SQ_W-1:0]   ii_ff, ii_in;
   logic [CNT_W-1:0]         k_ff, k_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]         rsp_row_ff, rsp_row_in;
   logic [PIX_W-1:0]         rsp_col_ff, rsp_col_in;
   logic [CNT_W-1:0]         rsp_count_ff, rsp_count_in;
   logic                     rsp_in_set_ff, rsp_in_set_in;

   logic [DIM_W-1:0]         width_ff, width_in;
   logic [DIM_W-1:0]         height_ff, height_in;
   logic [CNT_W-1:0]         max_iter_ff, max_iter_in;
   logic [THR_W-1:0]         thresh_ff, thresh_in;

   // divider hookup
   logic                     div_start;
   logic [NUM_W-1:0]         div_dividend;
   logic [DEN_W-1:0]         div_divisor;
   logic [NUM_W-1:0]         div_quotient;
   div_stat_type             div_stat;
   logic                     real_sel;
   logic [DIM_W-1:0]         dim_sel;
   logic [PIX_W-1:0]         pix_sel;
   logic [PIX_W-1:0]         half;
   logic [DEN_W-1:0]         quarter;
   logic                     coord_neg;
   logic [PIX_W-1:0]         coord_diff;

   // multiplier hookup
   logic signed [WORD_W-1:0] mul_a;
   logic signed [WORD_W-1:0] mul_b;
   logic signed [PROD_W-1:0] prod;

   logic signed [SQ_W-1:0]   sq_now;
   logic signed [RI_W-1:0]   ri_now;
   logic signed [ACC_W-1:0]  mag;
   logic [ACC_W-1:0]         thr_u;
   logic [CNT_W-1:0]         cap;
   logic                     accept;
   logic                     out_free;

   mbe_div #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quotient),
      .stat     (div_stat)
   );

   mbe_mult u_mult (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   // coordinate mapping operands: column against height, row against width
   always_comb begin
      real_sel   = (state_ff == ST_DIV_R_GO) || (state_ff == ST_DIV_R_WAIT);
      dim_sel    = real_sel ? height_ff : width_ff;
      pix_sel    = real_sel ? col_ff : row_ff;
      half       = dim_sel[DIM_W-1:1];
      quarter    = dim_sel[DIM_W-1:2];
      coord_neg  = (pix_sel < half);
      coord_diff = coord_neg ? (half - pix_sel) : (pix_sel - half);
      div_dividend = {coord_diff, {FRAC_BITS{1'b0}}};
      div_divisor  = (quarter == '0) ? DEN_W'(1) : quarter;
      div_start    = (state_ff == ST_DIV_R_GO) || (state_ff == ST_DIV_I_GO);
   end

   always_comb begin
      case (state_ff)
         ST_MUL_RR: begin
            mul_a = zr_ff;
            mul_b = zr_ff;
         end
         ST_MUL_II: begin
            mul_a = zi_ff;
            mul_b = zi_ff;
         end
         default: begin
            mul_a = zr_ff;
            mul_b = zi_ff;
         end
      endcase
   end

   always_comb begin
      accept   = req_valid && !req_stall;
      out_free = !rsp_valid_ff || !rsp_stall;
      cap      = (max_iter_ff == '0) ? CNT_W'(1) : max_iter_ff;
      // arithmetic shift of the product is the floor of the scaled value
      sq_now   = prod[PROD_W-1:FRAC_BITS];
      ri_now   = prod[PROD_W-1:FRAC_BITS-1];
      mag      = ACC_W'(rr_ff) + ACC_W'(sq_now);
      thr_u    = ACC_W'(thresh_ff) << FRAC_BITS;

      state_in      = state_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      cr_in         = cr_ff;
      ci_in         = ci_ff;
      zr_in         = zr_ff;
      zi_in         = zi_ff;
      rr_in         = rr_ff;
      ii_in         = ii_ff;
      k_in          = k_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_in_set_in = rsp_in_set_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               row_in   = req_row_index;
               col_in   = req_col_index;
               state_in = ST_DIV_R_GO;
            end
         end
         ST_DIV_R_GO: begin
            state_in = ST_DIV_R_WAIT;
         end
         ST_DIV_R_WAIT: begin
            if (div_stat.done) begin
               cr_in    = coord(coord_neg, div_quotient);
               state_in = ST_DIV_I_GO;
            end
         end
         ST_DIV_I_GO: begin
            state_in = ST_DIV_I_WAIT;
         end
         ST_DIV_I_WAIT: begin
            if (div_stat.done) begin
               ci_in    = coord(coord_neg, div_quotient);
               zr_in    = '0;
               zi_in    = '0;
               rr_in    = '0;
               ii_in    = '0;
               k_in     = '0;
               state_in = ST_MUL_RI;
            end
         end
         ST_MUL_RI: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            zr_in    = sat_acc(ACC_W'(rr_ff) - ACC_W'(ii_ff) + ACC_W'(cr_ff));
            zi_in    = sat_acc(ACC_W'(ri_now) + ACC_W'(ci_ff));
            k_in     = k_ff + CNT_W'(1);
            state_in = ST_MUL_RR;
         end
         ST_MUL_RR: begin
            state_in = ST_MUL_II;
         end
         ST_MUL_II: begin
            rr_in    = sq_now;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            ii_in = sq_now;
            if ((mag < $signed(thr_u)) && (k_ff != cap)) begin
               state_in = ST_MUL_RI;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_row_in    = row_ff;
               rsp_col_in    = col_ff;
               rsp_count_in  = k_ff;
               rsp_in_set_in = (k_ff == cap);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      width_in    = width_ff;
      height_in   = height_ff;
      max_iter_in = max_iter_ff;
      thresh_in   = thresh_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:      width_in    = csr_wdata[DIM_W-1:0];
            CSR_IMAGE_HEIGHT:     height_in   = csr_wdata[DIM_W-1:0];
            CSR_MAX_ITERATIONS:   max_iter_in = csr_wdata[CNT_W-1:0];
            CSR_ESCAPE_THRESHOLD: thresh_in   = csr_wdata[THR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      row_ff        <= row_in;
      col_ff        <= col_in;
      cr_ff         <= cr_in;
      ci_ff         <= ci_in;
      zr_ff         <= zr_in;
      zi_ff         <= zi_in;
      rr_ff         <= rr_in;
      ii_ff         <= ii_in;
      k_ff          <= k_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_in_set_ff <= rsp_in_set_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         width_ff     <= RST_IMAGE_WIDTH;
         height_ff    <= RST_IMAGE_HEIGHT;
         max_iter_ff  <= RST_MAX_ITERATIONS;
         thresh_ff    <= RST_ESCAPE_THRESHOLD;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         max_iter_ff  <= max_iter_in;
         thresh_ff    <= thresh_in;
      end
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_row  = rsp_row_ff;
   assign rsp_pixel_col  = rsp_col_ff;
   assign rsp_iter_count = rsp_count_ff;
   assign rsp_in_set     = rsp_in_set_ff;

   a_accept_starts_div: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_DIV_R_GO)
      else $error("accepted transaction did not start coordinate mapping");

   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == ST_DIV_R_WAIT) || (state_ff == ST_DIV_I_WAIT))
      else $error("divider result arrived outside a wait state");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) |-> (k_ff != '0) && (k_ff <= cap))
      else $error("iteration count out of range");

   a_busy_while_div: assert property (@(posedge clock) disable iff (reset)
      div_stat.busy |-> req_stall)
      else $error("input taken while divider runs");

   a_rsp_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_count_ff != '0)
      else $error("result transaction with zero iterations");

endmodule

`default_nettype wire

// ----- tb/tb_mandelbrot_escape_time.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mandelbrot_escape_time
// Drives pixels into the escape-time block under several image sizes,
// iteration caps and thresholds. Every result is checked field by field
// against an escape-time predictor run on the same register values.
// ----------------------------------------------------------------------------

module tb_mandelbrot_escape_time;
   import mbe_pkg::*;

   localparam int STALL_LIMIT = 1000000;   // cycles with no transaction at all
   localparam int HOLD_CYCLES = 600;       // receiver hold-off stretch
   localparam int TAIL_CYCLES = 400;
   localparam int PHASES      = 14;
   localparam int PHASE_ITEMS = 98;
   localparam int QUIET_PHASE = 3;         // no idling on either side
   localparam int HOLD_PHASE  = 6;

   typedef struct packed {
      logic [PIX_W-1:0] row;
      logic [PIX_W-1:0] col;
      logic [CNT_W-1:0] count;
      logic             in_set;
   } pixel_result_type;

   class escape_scoreboard_type;
      localparam int FRAC = 24;

      logic [DIM_W-1:0] width_reg;
      logic [DIM_W-1:0] height_reg;
      logic [CNT_W-1:0] cap_reg;
      logic [THR_W-1:0] thr_reg;
      pixel_result_type expected_q[$];
      int               mismatches;
      int               checked;
      int               in_set_seen;
      int               deepest;

      function new();
         width_reg   = RST_IMAGE_WIDTH;
         height_reg  = RST_IMAGE_HEIGHT;
         cap_reg     = RST_MAX_ITERATIONS;
         thr_reg     = RST_ESCAPE_THRESHOLD;
         mismatches  = 0;
         checked     = 0;
         in_set_seen = 0;
         deepest     = 0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] data);
         case (idx)
            CSR_IMAGE_WIDTH:      width_reg  = data[DIM_W-1:0];
            CSR_IMAGE_HEIGHT:     height_reg = data[DIM_W-1:0];
            CSR_MAX_ITERATIONS:   cap_reg    = data[CNT_W-1:0];
            CSR_ESCAPE_THRESHOLD: thr_reg    = data[THR_W-1:0];
            default: ;
         endcase
      endfunction

      function longint clamp_word(longint v);
         if (v > longint'(WORD_MAX)) return longint'(WORD_MAX);
         if (v < longint'(WORD_MIN)) return longint'(WORD_MIN);
         return v;
      endfunction

      // (p - dim/2) / (dim/4) in fixed point, truncated toward zero
      function longint map_axis(logic [PIX_W-1:0] p, logic [DIM_W-1:0] dim);
         longint half;
         longint quarter;
         longint num;
         half    = longint'(dim >> 1);
         quarter = longint'(dim >> 2);
         if (quarter == 0) quarter = 1;
         num = (longint'(p) - half) * (longint'(1) <<< FRAC);
         return clamp_word(num / quarter);
      endfunction

      function pixel_result_type escape_time(logic [PIX_W-1:0] row, logic [PIX_W-1:0] col);
         pixel_result_type res;
         longint cr, ci, zr, zi, rr, ii, ri, nr, mag, thr, mag_cap;
         int unsigned cap;
         int unsigned k;
         cr      = map_axis(col, height_reg);
         ci      = map_axis(row, width_reg);
         zr      = 0;
         zi      = 0;
         thr     = longint'(thr_reg) <<< FRAC;
         mag_cap = longint'(255) <<< FRAC;
         cap     = (cap_reg == 0) ? 1 : cap_reg;
         k       = 0;
         // arithmetic shifts on signed products give floor rounding
         do begin
            rr  = (zr * zr) >>> FRAC;
            ii  = (zi * zi) >>> FRAC;
            ri  = (zr * zi) >>> (FRAC - 1);
            nr  = clamp_word(rr - ii + cr);
            zi  = clamp_word(ri + ci);
            zr  = nr;
            mag = ((zr * zr) >>> FRAC) + ((zi * zi) >>> FRAC);
            if (mag > mag_cap) mag = mag_cap;
            k++;
         end while (mag < thr && k < cap);
         res.row    = row;
         res.col    = col;
         res.count  = k[CNT_W-1:0];
         res.in_set = (k == cap);
         return res;
      endfunction

      function void note_pixel(logic [PIX_W-1:0] row, logic [PIX_W-1:0] col);
         expected_q.push_back(escape_time(row, col));
      endfunction

      task report_mismatch(string what);
         $display("MISMATCH @%0t: %s", $realtime, what);
         mismatches++;
      endtask

      task check_pixel(logic [PIX_W-1:0] row, logic [PIX_W-1:0] col,
                       logic [CNT_W-1:0] count, logic in_set);
         pixel_result_type exp;
         checked++;
         if (in_set === 1'b1) in_set_seen++;
         if (int'(count) > deepest) deepest = int'(count);
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result for pixel (%0d,%0d)", row, col));
            return;
         end
         exp = expected_q.pop_front();
         if (row !== exp.row)
            report_mismatch($sformatf("pixel_row got %0d expected %0d", row, exp.row));
         if (col !== exp.col)
            report_mismatch($sformatf("pixel_col got %0d expected %0d", col, exp.col));
         if (count !== exp.count)
            report_mismatch($sformatf("pixel (%0d,%0d) iter_count got %0d expected %0d",
                                      exp.row, exp.col, count, exp.count));
         if (in_set !== exp.in_set)
            report_mismatch($sformatf("pixel (%0d,%0d) in_set got %0b expected %0b",
                                      exp.row, exp.col, in_set, exp.in_set));
      endtask

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [PIX_W-1:0]     req_row_index = '0;
   logic [PIX_W-1:0]     req_col_index = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [PIX_W-1:0]     rsp_pixel_row;
   logic [PIX_W-1:0]     rsp_pixel_col;
   logic [CNT_W-1:0]     rsp_iter_count;
   logic                 rsp_in_set;
   logic                 csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;

   escape_scoreboard_type board;
   int  pixels_sent    = 0;
   int  settings_count = 0;
   bit  tx_quiet       = 1'b0;
   bit  rx_quiet       = 1'b0;
   bit  hold_armed     = 1'b0;
   int  hold_left      = 0;

   mandelbrot_escape_time i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_row_index  (req_row_index),
      .req_col_index  (req_col_index),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel_row  (rsp_pixel_row),
      .rsp_pixel_col  (rsp_pixel_col),
      .rsp_iter_count (rsp_iter_count),
      .rsp_in_set     (rsp_in_set),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #6 clock = ~clock;

   // result side: check each accepted transaction, then choose next stall
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall)
         board.check_pixel(rsp_pixel_row, rsp_pixel_col, rsp_iter_count, rsp_in_set);
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (hold_armed) begin
         hold_armed = 1'b0;
         hold_left  = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !rx_quiet && ($urandom_range(0, 99) < 29);
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("TIMEOUT: no transaction for %0d cycles", STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   task automatic send_pixel(input logic [PIX_W-1:0] row, input logic [PIX_W-1:0] col);
      int gap;
      req_valid     <= 1'b1;
      req_row_index <= row;
      req_col_index <= col;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_pixel(row, col);
      pixels_sent++;
      gap = 0;
      while (!tx_quiet && $urandom_range(0, 99) < 29) gap++;
      if (gap > 0 && $urandom_range(0, 9) == 0) gap += $urandom_range(1, 150);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   // upper data bits of the narrow registers carry junk; the block must drop them
   task automatic program_registers(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                                    input logic [CNT_W-1:0] cap, input logic [THR_W-1:0] thr);
      logic [CSR_IDX_W-1:0] idx [4];
      logic [CSR_W-1:0]     val [4];
      idx = '{CSR_IMAGE_WIDTH, CSR_IMAGE_HEIGHT, CSR_MAX_ITERATIONS, CSR_ESCAPE_THRESHOLD};
      val = '{{3'($urandom), w}, {3'($urandom), h}, cap, {8'($urandom), thr}};
      for (int i = 0; i < 4; i++) begin
         csr_write <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
         board.write_register(idx[i], val[i]);
      end
      csr_write <= 1'b0;
      settings_count++;
   endtask

   function automatic logic [DIM_W-1:0] pick_dimension();
      case ($urandom_range(0, 9))
         0: return DIM_W'($urandom_range(0, 3));
         1: return DIM_W'($urandom_range(4097, 8191));
         2: return DIM_W'(4);
         3: return DIM_W'(4096);
         default: return DIM_W'($urandom_range(4, 4096));
      endcase
   endfunction

   task automatic run_random_phase(input int phase);
      logic [DIM_W-1:0] w, h;
      logic [CNT_W-1:0] cap;
      logic [THR_W-1:0] thr;
      logic [PIX_W-1:0] row, col;
      int               row_lim, col_lim, r;
      w = pick_dimension();
      h = pick_dimension();
      r = $urandom_range(0, 19);
      if (phase == HOLD_PHASE) cap = CNT_W'($urandom_range(2, 6));
      else if (r == 0)         cap = CNT_W'($urandom_range(0, 1));
      else if (r < 4)          cap = CNT_W'($urandom_range(41, 300));
      else                     cap = CNT_W'($urandom_range(1, 40));
      if ($urandom_range(0, 19) < 12) thr = THR_W'($urandom_range(2, 8));
      else                            thr = THR_W'($urandom_range(0, 255));
      program_registers(w, h, cap, thr);
      tx_quiet = (phase == QUIET_PHASE);
      rx_quiet = (phase == QUIET_PHASE);
      if (phase == HOLD_PHASE) hold_armed = 1'b1;
      row_lim = (w == 0) ? 0 : ((w > 4096) ? 4095 : w - 1);
      col_lim = (h == 0) ? 0 : ((h > 4096) ? 4095 : h - 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         // mostly pixels inside the image, where c spans the interesting region
         if ($urandom_range(0, 3) != 0) begin
            row = PIX_W'($urandom_range(0, row_lim));
            col = PIX_W'($urandom_range(0, col_lim));
         end else begin
            row = PIX_W'($urandom);
            col = PIX_W'($urandom);
         end
         send_pixel(row, col);
         if (n == PHASE_ITEMS / 2 && phase % 3 == 1) drain_results();
      end
      drain_results();
      tx_quiet = 1'b0;
      rx_quiet = 1'b0;
   endtask

   initial begin
      board = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // register defaults: 800x800, cap 256, threshold 4; center pixel stays in the set
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd4095, 12'd4095);
      send_pixel(12'd400, 12'd400);
      send_pixel(12'd400, 12'd0);
      send_pixel(12'd0, 12'd400);
      send_pixel(12'd4095, 12'd0);
      send_pixel(12'd0, 12'd4095);
      send_pixel(12'd400, 12'd200);
      drain_results();

      program_registers(13'd4, 13'd4, 16'd1, 8'd1);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd2, 12'd2);
      send_pixel(12'd4095, 12'd4095);
      drain_results();

      // quarter of the dimension is zero: divisor forced to one, far pixels saturate their coordinates
      program_registers(13'd3, 13'd1, 16'd16, 8'd255);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd1, 12'd1);
      send_pixel(12'd4095, 12'd4095);
      send_pixel(12'd2, 12'd3);
      drain_results();

      // zero cap and zero threshold together, then zero threshold alone
      program_registers(13'd4096, 13'd4096, 16'd0, 8'd0);
      send_pixel(12'd2048, 12'd2048);
      send_pixel(12'd0, 12'd0);
      drain_results();
      program_registers(13'd4096, 13'd4096, 16'd100, 8'd0);
      send_pixel(12'd2048, 12'd2048);
      send_pixel(12'd4095, 12'd1);
      drain_results();

      // largest cap and threshold; c = 0 runs the full 65535 iterations
      program_registers(13'd4096, 13'd4096, 16'd65535, 8'd255);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd2048, 12'd2048);
      send_pixel(12'd4095, 12'd4095);
      drain_results();

      // each phase drains its own results before returning
      for (int phase = 0; phase < PHASES; phase++)
         run_random_phase(phase);

      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Run covered %0d pixels under %0d register settings plus reset defaults",
               pixels_sent, settings_count);
      $display("%0d results checked, %0d in the set, deepest count %0d, %0d mismatches",
               board.checked, board.in_set_seen, board.deepest, board.mismatches);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
